// ===== rtl/cc20_pkg.sv =====
// Shared types, constants and helper functions of the ChaCha20 stream XOR block.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW  = 64;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY0      = 3'd0;
  localparam cfg_idx_t CFG_KEY1      = 3'd1;
  localparam cfg_idx_t CFG_KEY2      = 3'd2;
  localparam cfg_idx_t CFG_KEY3      = 3'd3;
  localparam cfg_idx_t CFG_NONCE_LO  = 3'd4;
  localparam cfg_idx_t CFG_NONCE_HI  = 3'd5;
  localparam cfg_idx_t CFG_START_CTR = 3'd6;

  // "expand 32-byte k"
  localparam logic [WordW-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WordW-1:0] SIGMA1 = 32'h3320_646e;
  localparam logic [WordW-1:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [WordW-1:0] SIGMA3 = 32'h6b20_6574;

  localparam int unsigned DoubleRounds = 10;

  // 4x4 word state, indexed [row][lane]
  typedef logic [3:0][3:0][WordW-1:0] blk_t;

  typedef struct packed {
    logic [3:0][CfgW-1:0] key;
    logic [CfgW-1:0]      nonce_lo;
    logic [WordW-1:0]     nonce_hi;
  } cc20_cfg_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] ctr;
  } cc20_ctrl_t;

  // Initial block state from key, nonce and block counter
  function automatic blk_t cc20_init(cc20_cfg_t cfg, logic [WordW-1:0] ctr);
    blk_t b;
    b[0][0] = SIGMA0;
    b[0][1] = SIGMA1;
    b[0][2] = SIGMA2;
    b[0][3] = SIGMA3;
    b[1][0] = cfg.key[0][31:0];
    b[1][1] = cfg.key[0][63:32];
    b[1][2] = cfg.key[1][31:0];
    b[1][3] = cfg.key[1][63:32];
    b[2][0] = cfg.key[2][31:0];
    b[2][1] = cfg.key[2][63:32];
    b[2][2] = cfg.key[3][31:0];
    b[2][3] = cfg.key[3][63:32];
    b[3][0] = ctr;
    b[3][1] = cfg.nonce_lo[31:0];
    b[3][2] = cfg.nonce_lo[63:32];
    b[3][3] = cfg.nonce_hi;
    return b;
  endfunction

  // Rotate left by the amount of quarter-round sub-step k (16, 12, 8, 7)
  function automatic logic [WordW-1:0] qr_rotl(logic [WordW-1:0] v, logic [1:0] k);
    logic [WordW-1:0] r;
    case (k)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cc20_core.sv =====
// ChaCha20 block generator: four-lane add/xor/rotate unit stepped by a small sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cc20_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cc20_pkg::cc20_cfg_t           cfg_i,
  input  cc20_pkg::cc20_ctrl_t          ctrl_i,
  input  logic [3:0]                    word_idx_i,
  output logic [cc20_pkg::WordW-1:0]    ks_word_o,
  output logic                          busy_o
);
  import cc20_pkg::*;

  localparam int unsigned DrW = $clog2(DoubleRounds);
  localparam logic [DrW-1:0] DrLast = DrW'(DoubleRounds - 1);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FEED} cstate_e;

  cstate_e        state_q, state_d;
  logic [1:0]     step_q, step_d;
  logic           diag_q, diag_d;
  logic [DrW-1:0] dr_q, dr_d;
  logic [WordW-1:0] ctr_q;
  blk_t           w_q, w_d;
  blk_t           init_start, init_feed;

  logic [3:0][1:0]       ia, ib, ic, id;
  logic [3:0][WordW-1:0] opx, opy, opz, sum_w, rot_w;

  assign init_start = cc20_init(cfg_i, ctrl_i.ctr);
  assign init_feed  = cc20_init(cfg_i, ctr_q);

  // Lane operand selection and the shared add/xor/rotate unit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      // diagonal rounds read rows 1..3 shifted by 1..3 lanes
      ia[i] = 2'(i);
      ib[i] = 2'(i) + {1'b0, diag_q};
      ic[i] = 2'(i) + {diag_q, 1'b0};
      id[i] = 2'(i) + {diag_q, diag_q};
      if (state_q == C_FEED) begin
        opx[i] = w_q[step_q][i];
        opy[i] = init_feed[step_q][i];
        opz[i] = w_q[step_q][i];
      end else if (!step_q[0]) begin
        opx[i] = w_q[0][ia[i]];
        opy[i] = w_q[1][ib[i]];
        opz[i] = w_q[3][id[i]];
      end else begin
        opx[i] = w_q[2][ic[i]];
        opy[i] = w_q[3][id[i]];
        opz[i] = w_q[1][ib[i]];
      end
      sum_w[i] = opx[i] + opy[i];
      rot_w[i] = qr_rotl(opz[i] ^ sum_w[i], step_q);
    end
  end

  // Sequencer and state write-back
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    diag_d  = diag_q;
    dr_d    = dr_q;
    w_d     = w_q;
    case (state_q)
      C_IDLE: begin
        if (ctrl_i.start) begin
          w_d     = init_start;
          state_d = C_ROUND;
          step_d  = 2'd0;
          diag_d  = 1'b0;
          dr_d    = '0;
        end
      end
      C_ROUND: begin
        for (int i = 0; i < 4; i++) begin
          if (!step_q[0]) begin
            w_d[0][ia[i]] = sum_w[i];
            w_d[3][id[i]] = rot_w[i];
          end else begin
            w_d[2][ic[i]] = sum_w[i];
            w_d[1][ib[i]] = rot_w[i];
          end
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          diag_d = !diag_q;
          if (diag_q) begin
            if (dr_q == DrLast) begin
              state_d = C_FEED;
              dr_d    = '0;
            end else begin
              dr_d = dr_q + DrW'(1);
            end
          end
        end
      end
      C_FEED: begin
        // feed-forward add, one row per cycle
        for (int i = 0; i < 4; i++) begin
          w_d[step_q][i] = sum_w[i];
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= 2'd0;
      diag_q  <= 1'b0;
      dr_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      diag_q  <= diag_d;
      dr_q    <= dr_d;
    end
  end

  // Working words and the counter of the block being made
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (state_q == C_IDLE && ctrl_i.start) begin
      ctr_q <= ctrl_i.ctr;
    end
  end

  assign ks_word_o = w_q[word_idx_i[3:2]][word_idx_i[1:0]];
  assign busy_o    = (state_q != C_IDLE);

endmodule

`default_nettype wire

// ===== rtl/chacha20_stream_xor_unit.sv =====
// Top level of the ChaCha20 stream XOR block: byte channel, config registers, keystream control.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one data byte with first/last flags per
//   transaction; output channel (out_valid_o/out_ready_i) returns that byte XORed with the
//   next keystream byte, with result_last_o copying the last flag.
//   Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) are registered; indexes 0..3 key,
//   4..5 nonce, 6 start counter, 7 ignored. Write only while no byte is in flight.
//   A byte that falls inside an already made block: result valid 1 cycle after accept,
//   next byte may be taken in the following cycle (one byte per cycle).
//   A byte that opens a block (first_of_message, or a 64-byte boundary): its result waits for
//   the block generator: the four-lane quarter-round unit runs 10 double rounds of 2 half
//   rounds of 4 sub-steps each, then adds 4 feed-forward rows; no new byte is taken meanwhile.
//   The result sits in an output register; a new byte is accepted while it is being taken.
//   If the receiver stalls, the result holds and in_ready_o stays low until it is free.
//   Reset clears the config registers, block counter and byte position; the first byte
//   after reset starts a block with counter zero.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_xor_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     first_of_message_i,
  input  logic                     last_of_message_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               result_byte_o,
  output logic                     result_last_o,
  input  logic                     cfg_we_i,
  input  cc20_pkg::cfg_idx_t       cfg_index_i,
  input  logic [cc20_pkg::CfgW-1:0] cfg_wdata_i
);
  import cc20_pkg::*;

  typedef enum logic {S_IDLE, S_WAIT} state_e;

  state_e           state_q;
  logic             out_valid_q;
  logic [7:0]       result_byte_q;
  logic             result_last_q;
  logic [5:0]       pos_q;
  logic             ks_ready_q;
  logic [WordW-1:0] blk_ctr_q;
  logic [7:0]       data_q;
  logic             last_q;

  logic [3:0][CfgW-1:0] key_q;
  logic [CfgW-1:0]      nonce_lo_q;
  logic [WordW-1:0]     nonce_hi_q;
  logic [WordW-1:0]     start_ctr_q;

  cc20_cfg_t        cfg;
  cc20_ctrl_t       ctrl;
  logic [WordW-1:0] ks_word;
  logic             core_busy;

  logic             out_free, in_acc, need_blk, emit;
  logic [WordW-1:0] ctr_sel;
  logic [7:0]       ks_byte, emit_byte;
  logic             emit_last;

  // Handshake and keystream decisions
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == S_IDLE) && out_free;
    in_acc     = in_valid_i && in_ready_o;
    need_blk   = first_of_message_i || !ks_ready_q;
    ctr_sel    = first_of_message_i ? start_ctr_q : blk_ctr_q;
    ctrl.start = in_acc && need_blk;
    ctrl.ctr   = ctr_sel;
    ks_byte    = ks_word[{pos_q[1:0], 3'b000} +: 8];
    emit       = (state_q == S_IDLE && in_acc && !need_blk) ||
                 (state_q == S_WAIT && !core_busy && out_free);
    emit_byte  = ((state_q == S_IDLE) ? data_byte_i : data_q) ^ ks_byte;
    emit_last  = (state_q == S_IDLE) ? last_of_message_i : last_q;
  end

  assign cfg.key      = key_q;
  assign cfg.nonce_lo = nonce_lo_q;
  assign cfg.nonce_hi = nonce_hi_q;

  cc20_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ctrl_i     (ctrl),
    .word_idx_i (pos_q[5:2]),
    .ks_word_o  (ks_word),
    .busy_o     (core_busy)
  );

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      result_byte_q <= '0;
      result_last_q <= 1'b0;
      pos_q         <= '0;
      ks_ready_q    <= 1'b0;
      blk_ctr_q     <= '0;
    end else begin
      if (in_acc && need_blk) begin
        state_q    <= S_WAIT;
        blk_ctr_q  <= ctr_sel + WordW'(1);
        ks_ready_q <= 1'b1;
        if (first_of_message_i) begin
          pos_q <= '0;
        end
      end
      if (emit) begin
        state_q       <= S_IDLE;
        out_valid_q   <= 1'b1;
        result_byte_q <= emit_byte;
        result_last_q <= emit_last;
        pos_q         <= pos_q + 6'd1;
        if (&pos_q) begin
          ks_ready_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Byte held while its block is made
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q <= data_byte_i;
      last_q <= last_of_message_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY0:      key_q[0]    <= cfg_wdata_i;
        CFG_KEY1:      key_q[1]    <= cfg_wdata_i;
        CFG_KEY2:      key_q[2]    <= cfg_wdata_i;
        CFG_KEY3:      key_q[3]    <= cfg_wdata_i;
        CFG_NONCE_LO:  nonce_lo_q  <= cfg_wdata_i;
        CFG_NONCE_HI:  nonce_hi_q  <= cfg_wdata_i[WordW-1:0];
        CFG_START_CTR: start_ctr_q <= cfg_wdata_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_byte_q;
  assign result_last_o = result_last_q;

endmodule

`default_nettype wire

// ===== rtl/cc20_checker.sv =====
// Port-level assertions for the ChaCha20 stream XOR block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cc20_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] result_byte_o,
  input logic       result_last_o
);

  // Input is only taken when the output register can take the result
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while output register is blocked");

  // An accepted byte either shows its result or blocks further input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (out_valid_o || !in_ready_o))
    else $error("second byte accepted before first result");

  // Idle with empty output and no transaction: stays ready
  a_idle_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i && !out_valid_o) |=> in_ready_o)
    else $error("ready dropped without a transaction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(result_byte_o) && $stable(result_last_o)))
    else $error("stalled result changed");

endmodule

bind chacha20_stream_xor_unit cc20_checker u_cc20_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_byte_o (result_byte_o),
  .result_last_o (result_last_o)
);

`default_nettype wire
